/* sv/wma_pkg.sv */
package wma_pkg;

   localparam int SAMPLE_W       = 10;
   localparam int AVG_W          = 16;
   localparam int DIV_W          = 16;
   localparam int WINDOW_DEFAULT = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [DIV_W-1:0] DIVISOR_RESET = 16'd36;
   localparam logic [AVG_W-1:0] AVG_MAX       = 16'hFFFF;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_FILL = 1'b1
   } op_type;

endpackage

/* sv/wma_if.sv */
interface wma_req_if;
   logic                        valid;
   logic                        ready;
   wma_pkg::op_type             operation;
   logic [wma_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface wma_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [wma_pkg::AVG_W-1:0] average;
   logic                      saturated;

   modport source (output valid, output average, output saturated, input ready);
   modport sink   (input valid, input average, input saturated, output ready);
endinterface

interface wma_csr_if;
   logic                      valid;
   logic                      ready;
   logic [wma_pkg::DIV_W-1:0] divisor;

   modport source (output valid, output divisor, input ready);
   modport sink   (input valid, input divisor, output ready);
endinterface

/* sv/weighted_moving_average.sv */
// channel  dir  handshake       payload
// req_if   in   valid/ready     operation (push/fill), sample[9:0]
// rsp_if   out  valid/ready     average[15:0], saturated
// csr_if   in   valid/ready     divisor[15:0]
//
// Front end updates the window and running sums in the cycle an item is taken.
// Back end divides one bit per cycle in a serial divider and takes no new
// item until its result is loaded (SUM_W = 16 bits at WINDOW 8).
// A two-entry queue separates the ends; the result register frees the divider.
// Synchronous reset clears the window to zero and the divisor to 36.
module weighted_moving_average #(
   parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   wma_req_if.sink   req_if,
   wma_rsp_if.source rsp_if,
   wma_csr_if.sink   csr_if
);

   localparam int SAMPLE_MAX = (1 << wma_pkg::SAMPLE_W) - 1;
   localparam int SUM_W      = $clog2(SAMPLE_MAX * WINDOW * (WINDOW + 1) / 2 + 1);

   logic             push_valid, push_ready;
   logic [SUM_W-1:0] push_sum;
   logic             pop_valid, pop_ready;
   logic [SUM_W-1:0] pop_sum;

   wma_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sum   (push_sum)
   );

   wma_queue #(
      .WIDTH (SUM_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_sum),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_sum)
   );

   wma_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_sum   (pop_sum),
      .csr_if    (csr_if),
      .rsp_if    (rsp_if)
   );

endmodule

/* sv/wma_front.sv */
module wma_front #(
   parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   wma_req_if.sink           req_if,
   output logic              push_valid,
   input  logic              push_ready,
   output logic [$clog2(((1 << wma_pkg::SAMPLE_W) - 1) * WINDOW * (WINDOW + 1) / 2 + 1)-1:0]
                             push_sum
);

   localparam int SAMPLE_MAX   = (1 << wma_pkg::SAMPLE_W) - 1;
   localparam int WEIGHT_TOTAL = WINDOW * (WINDOW + 1) / 2;
   localparam int SUM_W        = $clog2(SAMPLE_MAX * WEIGHT_TOTAL + 1);
   localparam int TOT_W        = $clog2(SAMPLE_MAX * WINDOW + 1);

   logic [wma_pkg::SAMPLE_W-1:0] window_ff [WINDOW];
   logic [wma_pkg::SAMPLE_W-1:0] window_in [WINDOW];
   logic [SUM_W-1:0]             wsum_ff, wsum_in;
   logic [TOT_W-1:0]             total_ff, total_in;
   logic                         accept;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;

   // running sums: shifting drops one of each weight, so S' = S - T + WINDOW*s
   always_comb begin
      window_in = window_ff;
      wsum_in   = wsum_ff;
      total_in  = total_ff;
      case (req_if.operation)
         wma_pkg::OP_PUSH: begin
            for (int i = 0; i < WINDOW - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[WINDOW - 1] = req_if.sample;
            wsum_in  = wsum_ff - SUM_W'(total_ff)
                     + SUM_W'(WINDOW) * SUM_W'(req_if.sample);
            total_in = total_ff - TOT_W'(window_ff[0]) + TOT_W'(req_if.sample);
         end
         wma_pkg::OP_FILL: begin
            for (int i = 0; i < WINDOW; i++) begin
               window_in[i] = req_if.sample;
            end
            wsum_in  = SUM_W'(WEIGHT_TOTAL) * SUM_W'(req_if.sample);
            total_in = TOT_W'(WINDOW) * TOT_W'(req_if.sample);
         end
         default: begin
            window_in = window_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
         wsum_ff  <= '0;
         total_ff <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         wsum_ff   <= wsum_in;
         total_ff  <= total_in;
      end
   end

   assign push_valid = accept;
   assign push_sum   = wsum_in;

endmodule

/* sv/wma_queue.sv */
module wma_queue #(
   parameter int WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int DEPTH = wma_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = data_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* sv/wma_back.sv */
module wma_back #(
   parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [$clog2(((1 << wma_pkg::SAMPLE_W) - 1) * WINDOW * (WINDOW + 1) / 2 + 1)-1:0]
                             pop_sum,
   wma_csr_if.sink           csr_if,
   wma_rsp_if.source         rsp_if
);

   localparam int SAMPLE_MAX = (1 << wma_pkg::SAMPLE_W) - 1;
   localparam int SUM_W      = $clog2(SAMPLE_MAX * WINDOW * (WINDOW + 1) / 2 + 1);
   localparam int CNT_W      = $clog2(SUM_W + 1);
   localparam int DIV_W      = wma_pkg::DIV_W;
   localparam int AVG_W      = wma_pkg::AVG_W;
   localparam int EXT_W      = SUM_W + AVG_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [DIV_W-1:0] divisor_ff;
   logic [SUM_W-1:0] quot_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic [AVG_W-1:0] average_ff;
   logic             saturated_ff;

   logic [DIV_W:0]   rem_shift;
   logic [DIV_W:0]   rem_diff;
   logic             rem_ge;
   logic [EXT_W-1:0] quot_ext;
   logic             over;
   logic             out_free;
   logic             out_load;

   // one quotient bit per cycle, restoring
   assign rem_shift = {rem_ff, quot_ff[SUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, divisor_ff};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign quot_ext  = EXT_W'(quot_ff);
   assign over      = (divisor_ff == '0) || (quot_ext > EXT_W'(wma_pkg::AVG_MAX));
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign out_load  = (state_ff == ST_DONE) && out_free;

   assign pop_ready        = (state_ff == ST_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.average   = average_ff;
   assign rsp_if.saturated = saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         divisor_ff   <= wma_pkg::DIVISOR_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_if.valid) begin
            divisor_ff <= csr_if.divisor;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  quot_ff  <= pop_sum;
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(SUM_W);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               quot_ff <= {quot_ff[SUM_W-2:0], rem_ge};
               rem_ff  <= rem_ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  average_ff   <= over ? wma_pkg::AVG_MAX : quot_ext[AVG_W-1:0];
                  saturated_ff <= over;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
